[rtl/core/brle_pkg.sv]
// ----------------------------------------------------------------------------
// brle_pkg
// Shared types and constants for the binary row run-length encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

    localparam int COL_W       = 12;
    localparam int WIDTH_W     = 13;
    localparam int PIX_W       = 8;
    localparam int MAX_WIDTH   = 4096;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PIX_W-1:0]   PIX_WHITE     = 8'd255;
    localparam logic [PIX_W-1:0]   PIX_BLACK     = 8'd0;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET   = 13'd640;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX     = 13'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0] WIDTH_MIN     = 13'd1;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_ROW_WIDTH = 3'd0;

    typedef struct packed {
        logic [COL_W-1:0] run_begin;
        logic [COL_W-1:0] run_finish;
        logic             row_end_marker;
        logic             last;
    } result_t;

    // results produced by one pixel transaction, res0 goes out first
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

[rtl/core/binary_row_run_length_encoder_top.sv]
// A pixel is registered, then its results enter the queue once the queue has room;
//   the first result shows on m_valid once it is held in the queue.
// Throughput: one pixel per cycle while the queue has room; a row end that closes
//   a run gives two results; the four-entry queue pops one per cycle with m_ready.
// Reset: synchronous active-low aresetn clears column, run state and queue,
//   row_width returns to 640.
// ----------------------------------------------------------------------------
// binary_row_run_length_encoder_top
// Run-length encoder for binary image rows with an APB row width register.
// ----------------------------------------------------------------------------
module binary_row_run_length_encoder_top
    import brle_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIX_W-1:0]   s_pixel,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COL_W-1:0]   m_run_begin,
    output logic [COL_W-1:0]   m_run_finish,
    output logic               m_row_end_marker,
    output logic               m_last
);

    logic [WIDTH_W-1:0] row_width_reg, row_width_next;
    logic               wr_en;
    logic               addr_hit;
    logic               room;
    push_t              push;

    assign pready   = 1'b1;
    assign addr_hit = paddr[PADDR_W-1:2] == ADDR_ROW_WIDTH[PADDR_W-1:2];
    assign wr_en    = psel && penable && pwrite && pready && addr_hit;
    assign prdata   = addr_hit ? {{(32-WIDTH_W){1'b0}}, row_width_reg} : '0;

    always_comb begin
        row_width_next = wr_en ? pwdata[WIDTH_W-1:0] : row_width_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= WIDTH_RESET;
        end else begin
            row_width_reg <= row_width_next;
        end
    end

    brle_encoder u_encoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .row_width (row_width_reg),
        .room      (room),
        .push      (push)
    );

    brle_out_queue u_out_queue (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .push             (push),
        .room             (room),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_run_begin      (m_run_begin),
        .m_run_finish     (m_run_finish),
        .m_row_end_marker (m_row_end_marker),
        .m_last           (m_last)
    );

endmodule

[rtl/core/brle_encoder.sv]
// ----------------------------------------------------------------------------
// brle_encoder
// Input register, row/run state and result generation for one pixel.
// ----------------------------------------------------------------------------
module brle_encoder
    import brle_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIX_W-1:0]   s_pixel,
    input  logic [WIDTH_W-1:0] row_width,
    input  logic               room,
    output push_t              push
);

    logic               in_valid_reg, in_valid_next;
    logic [PIX_W-1:0]   pixel_reg;
    logic [COL_W-1:0]   column_reg, column_next;
    logic               in_run_reg, in_run_next;
    logic [COL_W-1:0]   open_start_reg, open_start_next;

    logic               consume;
    logic [WIDTH_W-1:0] eff_width;
    logic [WIDTH_W-1:0] col_plus;
    logic               row_end;
    logic               open_now;
    logic               run_open;
    logic [COL_W-1:0]   start_col;
    logic               close_zero;
    logic               close_end;
    logic               run_out;
    result_t            run_res;
    result_t            mark_res;

    assign consume = in_valid_reg && room;
    assign s_ready = !in_valid_reg || consume;

    always_comb begin
        if (row_width == '0) begin
            eff_width = WIDTH_MIN;
        end else if (row_width > WIDTH_MAX) begin
            eff_width = WIDTH_MAX;
        end else begin
            eff_width = row_width;
        end
    end

    assign col_plus   = {1'b0, column_reg} + WIDTH_W'(1);
    assign row_end    = col_plus >= eff_width;
    assign open_now   = !in_run_reg && (pixel_reg == PIX_WHITE);
    assign run_open   = in_run_reg || open_now;
    assign start_col  = open_now ? column_reg : open_start_reg;
    assign close_zero = run_open && (pixel_reg == PIX_BLACK);
    assign close_end  = run_open && !close_zero && row_end;
    assign run_out    = close_zero || close_end;

    always_comb begin
        run_res.run_begin      = start_col;
        run_res.run_finish     = close_zero ? column_reg - COL_W'(1) : column_reg;
        run_res.row_end_marker = 1'b0;
        run_res.last           = !row_end;
        mark_res.run_begin      = '0;
        mark_res.run_finish     = '0;
        mark_res.row_end_marker = 1'b1;
        mark_res.last           = 1'b1;
    end

    always_comb begin
        push.count = '0;
        push.res0  = run_out ? run_res : mark_res;
        push.res1  = mark_res;
        if (consume) begin
            push.count = {1'b0, run_out} + {1'b0, row_end};
        end
    end

    always_comb begin
        in_valid_next   = in_valid_reg;
        column_next     = column_reg;
        in_run_next     = in_run_reg;
        open_start_next = open_start_reg;
        if (consume) begin
            in_valid_next = 1'b0;
            in_run_next   = run_open && !run_out;
            if (open_now) begin
                open_start_next = column_reg;
            end
            column_next = row_end ? '0 : col_plus[COL_W-1:0];
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            column_reg     <= '0;
            in_run_reg     <= 1'b0;
            open_start_reg <= '0;
        end else begin
            in_valid_reg   <= in_valid_next;
            column_reg     <= column_next;
            in_run_reg     <= in_run_next;
            open_start_reg <= open_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pixel_reg <= s_pixel;
        end
    end

endmodule

[rtl/core/brle_out_queue.sv]
// ----------------------------------------------------------------------------
// brle_out_queue
// Small result queue taking up to two results per cycle, one out per cycle with m_ready.
// ----------------------------------------------------------------------------
module brle_out_queue
    import brle_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  push_t            push,
    output logic             room,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [COL_W-1:0] m_run_begin,
    output logic [COL_W-1:0] m_run_finish,
    output logic             m_row_end_marker,
    output logic             m_last
);

    result_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                pop;
    result_t             head;

    // room for the worst case of two results from one pixel
    assign room    = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign m_valid = count_reg != '0;
    assign pop     = m_valid && m_ready;
    assign head    = entry_reg[rd_ptr_reg];

    assign m_run_begin      = head.run_begin;
    assign m_run_finish     = head.run_finish;
    assign m_row_end_marker = head.row_end_marker;
    assign m_last           = head.last;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_reg + QPTR_W'(1)] <= push.res1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> room)
        else $error("results pushed without room");

    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd2) |-> (!push.res0.last && !push.res0.row_end_marker
                                  && push.res1.last && push.res1.row_end_marker))
        else $error("run and marker pair out of order");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count == 2'd1) |-> push.res0.last)
        else $error("single result without last");

    a_no_three: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd3)
        else $error("more than two results from one pixel");

endmodule
